// ===== design/minicomputer_alu_with_flags_core_defines.svh =====
// ----------------------------------------------------------------------------
// minicomputer_alu_with_flags_core_defines
// Assertion macros for the minicomputer alu core.
// ----------------------------------------------------------------------------
`ifndef MINICOMPUTER_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define MINICOMPUTER_ALU_WITH_FLAGS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define MCALU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mcalu assertion failed");
// consequent holds in the cycle after the antecedent
`define MCALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcalu assertion failed");
`else
`define MCALU_ASSERT(label, clk, rst_n, prop)
`define MCALU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/mcalu_pkg.sv =====
// ----------------------------------------------------------------------------
// mcalu_pkg
// Opcodes and flag type shared by the minicomputer alu core and its datapath.
// ----------------------------------------------------------------------------
package mcalu_pkg;

    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_MOV  = 5'd0,
        OP_MOVB = 5'd1,
        OP_MUL  = 5'd2,
        OP_NEG  = 5'd3,
        OP_NEGB = 5'd4,
        OP_ROL  = 5'd5,
        OP_ROR  = 5'd6,
        OP_SBC  = 5'd7,
        OP_SBCB = 5'd8,
        OP_SCC  = 5'd9,
        OP_SEC  = 5'd10,
        OP_SEN  = 5'd11,
        OP_SEV  = 5'd12,
        OP_SEZ  = 5'd13,
        OP_SUB  = 5'd14,
        OP_SWAB = 5'd15,
        OP_SXT  = 5'd16,
        OP_TST  = 5'd17,
        OP_TSTB = 5'd18,
        OP_XOR  = 5'd19
    } t_op;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } t_flags;

    localparam logic [WORD_W-1:0] WORD_MIN = 16'h8000;
    localparam logic [BYTE_W-1:0] BYTE_MIN = 8'h80;

endpackage

// ===== design/minicomputer_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// minicomputer_alu_with_flags_core
// 16-bit alu with n/z/v/c condition flags, one operation per transaction.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry opcode, source and destination
// words and the byte-half selectors. Output channel: o_out_valid / i_out_stall
// carry the result word, the high product word and the four flags.
// A transaction is taken on a rising edge with valid high and stall low.
// An operation passes an input register, then the alu and 16x16 multiplier
// into the result register, with the flag register written on the same edge.
// Throughput is one operation per cycle unless the receiver stalls. The flag
// register feeds the next operation directly; dependent ops run back to back.
// Reset (i_rst_n low, synchronous) empties both stages and clears all flags.
// While the receiver stalls, the result register holds; one more transaction
// is taken into the input register, and o_in_stall rises once that is full
// behind a waiting result.
// ----------------------------------------------------------------------------
`include "minicomputer_alu_with_flags_core_defines.svh"

module minicomputer_alu_with_flags_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mcalu_pkg::OP_W-1:0]          i_op,
    input  logic signed [mcalu_pkg::WORD_W-1:0] i_src_word,
    input  logic signed [mcalu_pkg::WORD_W-1:0] i_dst_word,
    input  logic                                i_src_high,
    input  logic                                i_dst_high,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mcalu_pkg::WORD_W-1:0] o_result_word,
    output logic signed [mcalu_pkg::WORD_W-1:0] o_product_high,
    output logic                                o_flag_n,
    output logic                                o_flag_z,
    output logic                                o_flag_v,
    output logic                                o_flag_c
);
    import mcalu_pkg::*;

    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [WORD_W-1:0] r_in_src;
    logic [WORD_W-1:0] r_in_dst;
    logic              r_in_sh;
    logic              r_in_dh;

    logic              r_out_valid;
    logic              r_out_mul;
    logic [WORD_W-1:0] r_out_res;
    logic [WORD_W-1:0] r_out_hi;
    t_flags            r_flags;

    logic              out_free;
    logic              advance;
    logic              in_take;
    logic [WORD_W-1:0] n_res;
    logic [WORD_W-1:0] n_hi;
    t_flags            n_flags;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    mcalu_exec u_exec (
        .i_op        (r_in_op),
        .i_src       (r_in_src),
        .i_dst       (r_in_dst),
        .i_src_high  (r_in_sh),
        .i_dst_high  (r_in_dh),
        .i_flags     (r_flags),
        .o_res       (n_res),
        .o_prod_high (n_hi),
        .o_flags     (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= i_op;
            r_in_src <= i_src_word;
            r_in_dst <= i_dst_word;
            r_in_sh  <= i_src_high;
            r_in_dh  <= i_dst_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= n_res;
            r_out_hi  <= n_hi;
            r_out_mul <= (r_in_op == OP_MUL);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_word  = r_out_res;
    assign o_product_high = r_out_hi;
    assign o_flag_n       = r_flags.n;
    assign o_flag_z       = r_flags.z;
    assign o_flag_v       = r_flags.v;
    assign o_flag_c       = r_flags.c;

    // upstream only sees stall behind a full input stage and a waiting result
    `MCALU_ASSERT(a_stall_cause, i_clk, i_rst_n,
        !o_in_stall || (r_in_valid && r_out_valid && i_out_stall))
    // a result that moves out with a full input stage is replaced at once
    `MCALU_ASSERT_NEXT(a_refill, i_clk, i_rst_n,
        r_in_valid && out_free, r_out_valid)
    // only a multiply leaves a nonzero high word
    `MCALU_ASSERT(a_hi_zero, i_clk, i_rst_n,
        !r_out_valid || r_out_mul || (r_out_hi == '0))
    // flags shown with a waiting result stay put until it leaves
    `MCALU_ASSERT_NEXT(a_flags_hold, i_clk, i_rst_n,
        r_out_valid && i_out_stall, $stable(r_flags))

endmodule

// ===== design/mcalu_exec.sv =====
// ----------------------------------------------------------------------------
// mcalu_exec
// Combinational datapath: result word, high product word and new flags.
// ----------------------------------------------------------------------------
module mcalu_exec (
    input  logic [mcalu_pkg::OP_W-1:0]   i_op,
    input  logic [mcalu_pkg::WORD_W-1:0] i_src,
    input  logic [mcalu_pkg::WORD_W-1:0] i_dst,
    input  logic                         i_src_high,
    input  logic                         i_dst_high,
    input  mcalu_pkg::t_flags            i_flags,
    output logic [mcalu_pkg::WORD_W-1:0] o_res,
    output logic [mcalu_pkg::WORD_W-1:0] o_prod_high,
    output mcalu_pkg::t_flags            o_flags
);
    import mcalu_pkg::*;

    logic [BYTE_W-1:0]     sb;
    logic [BYTE_W-1:0]     db;
    logic [BYTE_W-1:0]     b;
    logic [2*WORD_W-1:0]   prod;
    logic [WORD_W:0]       diff;
    logic                  cin;

    assign sb   = i_src_high ? i_src[15:8] : i_src[7:0];
    assign db   = i_dst_high ? i_dst[15:8] : i_dst[7:0];
    assign cin  = i_flags.c;
    assign prod = 32'($signed(i_dst) * $signed(i_src));
    assign diff = {1'b0, i_dst} - {1'b0, i_src};

    always_comb begin
        o_res       = i_dst;
        o_prod_high = '0;
        o_flags     = i_flags;
        b           = '0;
        unique case (t_op'(i_op))
            OP_MOV: begin
                o_res     = i_src;
                o_flags.n = i_src[15];
                o_flags.z = (i_src == '0);
                o_flags.v = 1'b0;
            end
            OP_MOVB: begin
                o_res     = i_dst_high ? {sb, i_dst[7:0]} : {i_dst[15:8], sb};
                o_flags.n = sb[7];
                o_flags.z = (sb == '0);
                o_flags.v = 1'b0;
            end
            OP_MUL: begin
                o_res       = prod[15:0];
                o_prod_high = prod[31:16];
                o_flags.n   = prod[31];
                o_flags.z   = (prod == '0);
                o_flags.v   = 1'b0;
                // product fits in a word only if the top 17 bits agree
                o_flags.c   = !((prod[31:15] == '0) || (prod[31:15] == '1));
            end
            OP_NEG: begin
                o_res     = WORD_W'(16'h0 - i_dst);
                o_flags.n = o_res[15];
                o_flags.z = (o_res == '0);
                o_flags.v = (o_res == WORD_MIN);
                o_flags.c = (o_res != '0);
            end
            OP_NEGB: begin
                b         = BYTE_W'(8'h0 - db);
                o_res     = i_dst_high ? {b, i_dst[7:0]} : {i_dst[15:8], b};
                o_flags.n = b[7];
                o_flags.z = (b == '0);
                o_flags.v = (b == BYTE_MIN);
                o_flags.c = (b != '0);
            end
            OP_ROL: begin
                o_res     = {i_dst[14:0], cin};
                o_flags.n = i_dst[14];
                o_flags.z = (o_res == '0);
                o_flags.c = i_dst[15];
                o_flags.v = i_dst[14] ^ i_dst[15];
            end
            OP_ROR: begin
                o_res     = {cin, i_dst[15:1]};
                o_flags.n = cin;
                o_flags.z = (o_res == '0);
                o_flags.c = i_dst[0];
                o_flags.v = cin ^ i_dst[0];
            end
            OP_SBC: begin
                o_res     = i_dst - {15'h0, cin};
                o_flags.n = o_res[15];
                o_flags.z = (o_res == '0);
                o_flags.v = (i_dst == WORD_MIN) && cin;
                o_flags.c = (i_dst == '0) && cin;
            end
            OP_SBCB: begin
                b         = db - {7'h0, cin};
                o_res     = i_dst_high ? {b, i_dst[7:0]} : {i_dst[15:8], b};
                o_flags.n = b[7];
                o_flags.z = (b == '0);
                o_flags.v = (db == BYTE_MIN) && cin;
                o_flags.c = (db == '0) && cin;
            end
            OP_SCC: o_flags = '1;
            OP_SEC: o_flags.c = 1'b1;
            OP_SEN: o_flags.n = 1'b1;
            OP_SEV: o_flags.v = 1'b1;
            OP_SEZ: o_flags.z = 1'b1;
            OP_SUB: begin
                o_res     = diff[15:0];
                o_flags.n = diff[15];
                o_flags.z = (diff[15:0] == '0);
                o_flags.v = (i_dst[15] ^ i_src[15]) & (i_dst[15] ^ diff[15]);
                o_flags.c = diff[16];
            end
            OP_SWAB: begin
                o_res     = {i_dst[7:0], i_dst[15:8]};
                o_flags.n = i_dst[15];
                o_flags.z = (i_dst[15:8] == '0);
                o_flags.v = 1'b0;
                o_flags.c = 1'b0;
            end
            OP_SXT: begin
                o_res     = {WORD_W{i_flags.n}};
                o_flags.z = !i_flags.n;
                o_flags.v = 1'b0;
            end
            OP_TST: begin
                o_flags.n = i_dst[15];
                o_flags.z = (i_dst == '0);
                o_flags.v = 1'b0;
                o_flags.c = 1'b0;
            end
            OP_TSTB: begin
                o_flags.n = db[7];
                o_flags.z = (db == '0);
                o_flags.v = 1'b0;
                o_flags.c = 1'b0;
            end
            OP_XOR: begin
                o_res     = i_dst ^ i_src;
                o_flags.n = o_res[15];
                o_flags.z = (o_res == '0);
                o_flags.v = 1'b0;
            end
            default: begin
                // unused opcodes leave everything as it was
                o_res   = i_dst;
                o_flags = i_flags;
            end
        endcase
    end

endmodule
